### rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion helpers shared by the rasterizer RTL; empty for synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Invariant sampled on every clock edge outside reset.
`define RPDR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RPDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RPDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RPDR_ASSERT(lbl, prop, msg)
`define RPDR_ASSERT_IMP(lbl, ante, cons, msg)
`define RPDR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/rpdr_pkg.sv
// ============================================================================
// rpdr_pkg
// Shared types, codes and constants of the point density rasterizer.
// ============================================================================
package rpdr_pkg;

    localparam int BINS_PER_ROW = 4;
    localparam int BINS_PER_COL = 2;

    // Last cycle of the projection/binning pipeline, counted from zero
    localparam logic [2:0] PIPE_LAST = 3'd6;

    localparam logic [18:0] THR_MAGENTA = 19'd10000;
    localparam logic [18:0] THR_RED     = 19'd3010;
    localparam logic [18:0] THR_YELLOW  = 19'd1000;
    localparam logic [18:0] THR_GREEN   = 19'd301;
    localparam logic [18:0] THR_CYAN    = 19'd100;
    localparam logic [18:0] THR_WHITE   = 19'd30;

    typedef enum logic [1:0] {
        REQ_PLOT  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_COS_THETA = 3'd0,
        CFG_SIN_THETA = 3'd1,
        CFG_COS_PHI   = 3'd2,
        CFG_SIN_PHI   = 3'd3,
        CFG_RANGE_MIN = 3'd4,
        CFG_X_SCALE   = 3'd5,
        CFG_Y_SCALE   = 3'd6,
        CFG_PLOT_COLS = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        COLOR_NONE    = 3'd0,
        COLOR_WHITE   = 3'd1,
        COLOR_CYAN    = 3'd2,
        COLOR_GREEN   = 3'd3,
        COLOR_YELLOW  = 3'd4,
        COLOR_RED     = 3'd5,
        COLOR_MAGENTA = 3'd6
    } color_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_CELL_RD,
        ST_CELL_DRAIN,
        ST_CLEAR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [6:0]         cell_col;
        logic [4:0]         cell_row;
    } item_t;

    typedef struct packed {
        logic        in_range;
        logic [7:0]  cell_code;
        logic [2:0]  color_class;
        logic [18:0] cell_total;
    } result_t;

    typedef struct packed {
        logic cap;       // capture the request
        logic clr_we;    // zero the store entry under the sweep counter
        logic rd_issue;  // read the next bin of the cell
        logic bin_we;    // write back the incremented bin
        logic fin;       // load the result and strobe it
    } cmd_t;

    typedef struct packed {
        logic bin_ok;
        logic cell_ok;
        logic clr_last;
        logic k_last;
    } status_t;

    function automatic color_t color_of(input logic [18:0] total);
        color_t c;
        if (total > THR_MAGENTA)     c = COLOR_MAGENTA;
        else if (total > THR_RED)    c = COLOR_RED;
        else if (total > THR_YELLOW) c = COLOR_YELLOW;
        else if (total > THR_GREEN)  c = COLOR_GREEN;
        else if (total > THR_CYAN)   c = COLOR_CYAN;
        else if (total > THR_WHITE)  c = COLOR_WHITE;
        else                         c = COLOR_NONE;
        return c;
    endfunction

endpackage

### rtl/rpdr_ram.sv
// ============================================================================
// rpdr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rpdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rpdr_ctrl.sv
// ============================================================================
// rpdr_ctrl
// Sequencer: clearing sweep, plot pipeline wait, bin update, cell read.
// ============================================================================
`include "assert_macros.svh"

module rpdr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       req_type,
    input  rpdr_pkg::status_t status,
    output rpdr_pkg::cmd_t   cmd,
    output logic             busy
);
    import rpdr_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = 3'd0;
        case (state_reg)
            ST_INIT:
            begin
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_PLOT:  state_next = ST_CALC;
                        REQ_READ:  state_next = ST_CELL_RD;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_CALC:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == PIPE_LAST) state_next = ST_BIN_RD;
            end
            ST_BIN_RD:     state_next = status.bin_ok ? ST_BIN_WR : ST_FIN;
            ST_BIN_WR:     state_next = ST_FIN;
            ST_CELL_RD:
            begin
                if (!status.cell_ok)    state_next = ST_FIN;
                else if (status.k_last) state_next = ST_CELL_DRAIN;
            end
            ST_CELL_DRAIN: state_next = ST_FIN;
            ST_CLEAR:
            begin
                if (status.clr_last) state_next = ST_FIN;
            end
            ST_FIN:        state_next = ST_IDLE;
            default:       state_next = ST_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.cap      = (state_reg == ST_IDLE) && start;
        cmd.clr_we   = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        cmd.rd_issue = (state_reg == ST_CELL_RD) && status.cell_ok;
        cmd.bin_we   = (state_reg == ST_BIN_WR);
        cmd.fin      = (state_reg == ST_FIN);
        busy         = (state_reg != ST_IDLE);
    end

    `RPDR_ASSERT_NXT(a_accept_busy, start && (state_reg == ST_IDLE), busy, "accept did not raise busy")
    `RPDR_ASSERT_NXT(a_fin_idle, cmd.fin, state_reg == ST_IDLE, "no return to idle after result")
    `RPDR_ASSERT(a_wr_excl, !(cmd.clr_we && cmd.bin_we), "clear and bin write collide")
    `RPDR_ASSERT_IMP(a_bin_wr_order, cmd.bin_we, $past(state_reg) == ST_BIN_RD, "bin write without read")

endmodule

### rtl/rpdr_datapath.sv
// ============================================================================
// rpdr_datapath
// Config registers, projection and binning pipeline, bin store and results.
// ============================================================================
module rpdr_datapath #(
    parameter int MAX_COLS  = 128,
    parameter int GRID_ROWS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [31:0]       cfg_data,
    input  rpdr_pkg::item_t   item,
    input  rpdr_pkg::cmd_t    cmd,
    output rpdr_pkg::status_t status,
    output rpdr_pkg::result_t result,
    output logic              done
);
    import rpdr_pkg::*;

    localparam int BINS_DOWN = GRID_ROWS * BINS_PER_ROW;
    localparam int DEPTH     = MAX_COLS * BINS_PER_COL * BINS_DOWN;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int BX_W      = $clog2(MAX_COLS * BINS_PER_COL);
    localparam int BY_W      = $clog2(BINS_DOWN);
    localparam logic [39:0] BMAX = 40'(BINS_DOWN - 1);

    // Configuration
    logic signed [15:0] cos_theta_reg, sin_theta_reg, cos_phi_reg, sin_phi_reg;
    logic signed [31:0] range_min_reg;
    logic [31:0]        x_scale_reg, y_scale_reg;
    logic [7:0]         plot_cols_reg;
    logic [31:0]        eff_cols;
    logic [39:0]        across;

    // Captured request
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [1:0]         req_reg;
    logic [6:0]         col_reg;
    logic [4:0]         row_reg;
    logic               cell_ok_reg, cell_ok_next;

    // Pipeline
    logic signed [47:0] mxc_reg, mys_reg, mxs_reg, myc_reg, mzs_reg;
    logic signed [47:0] mxc_next, mys_next, mxs_next, myc_next, mzs_next;
    logic signed [48:0] sxy, dyx;
    logic signed [34:0] px_reg, px_next, inner_reg, inner_next;
    logic signed [47:0] zs_reg, zs_next, zs2_reg, zs2_next;
    logic signed [50:0] ic_reg, ic_next;
    logic signed [35:0] ex_reg, ex_next, ex2_reg, ex2_next;
    logic signed [51:0] dz;
    logic signed [37:0] py;
    logic signed [38:0] ey_reg, ey_next, exw;
    logic [38:0]        magx, magy;
    logic [63:0]        xlo_reg, xlo_next, ylo_reg, ylo_next;
    logic [38:0]        xhi_reg, xhi_next, yhi_reg, yhi_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;
    logic [39:0]        qx_reg, qx_next, qy_reg, qy_next;
    logic               fy_reg, fy_next, negx2_reg, negx2_next, negy2_reg, negy2_next;
    logic [39:0]        bx_w, by_w;
    logic               bx_ok, by_ok;
    logic               bin_ok_reg, bin_ok_next;
    logic [ADDR_W-1:0]  bin_addr_reg, bin_addr_next;

    // Store access and cell accumulation
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next, cell_addr, ram_waddr, ram_raddr;
    logic               clr_last, ram_we;
    logic [15:0]        ram_wdata, ram_rdata;
    logic [31:0]        cell_bx, cell_by;
    logic [2:0]         k_reg, k_next, acc_k_reg;
    logic               acc_v_reg;
    logic [18:0]        total_reg, total_next;
    logic [7:0]         code_reg, code_next;
    result_t            result_reg, result_next;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_theta_reg <= 16'sd16384;
            sin_theta_reg <= 16'sd0;
            cos_phi_reg   <= 16'sd16384;
            sin_phi_reg   <= 16'sd0;
            range_min_reg <= 32'sd0;
            x_scale_reg   <= 32'd65536;
            y_scale_reg   <= 32'd65536;
            plot_cols_reg <= 8'd68;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_COS_THETA: cos_theta_reg <= cfg_data[15:0];
                CFG_SIN_THETA: sin_theta_reg <= cfg_data[15:0];
                CFG_COS_PHI:   cos_phi_reg   <= cfg_data[15:0];
                CFG_SIN_PHI:   sin_phi_reg   <= cfg_data[15:0];
                CFG_RANGE_MIN: range_min_reg <= cfg_data;
                CFG_X_SCALE:   x_scale_reg   <= cfg_data;
                CFG_Y_SCALE:   y_scale_reg   <= cfg_data;
                CFG_PLOT_COLS: plot_cols_reg <= cfg_data[7:0];
                default:       plot_cols_reg <= plot_cols_reg;
            endcase
        end
    end

    // Column count clamps at the store width
    assign eff_cols = (32'(plot_cols_reg) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
                                                            : 32'(plot_cols_reg);
    assign across   = 40'(eff_cols) * 40'(BINS_PER_COL);

    always_comb
    begin
        cell_ok_next = (32'(item.cell_col) < eff_cols) && (32'(item.cell_row) < 32'(GRID_ROWS));

        // Stage A: rotation products
        mxc_next = x_reg * cos_theta_reg;
        mys_next = y_reg * sin_theta_reg;
        mxs_next = x_reg * sin_theta_reg;
        myc_next = y_reg * cos_theta_reg;
        mzs_next = z_reg * sin_phi_reg;

        // Stage B: floor to Q16.16
        sxy        = mxc_reg + mys_reg;
        dyx        = myc_reg - mxs_reg;
        px_next    = sxy[48:14];
        inner_next = dyx[48:14];
        zs_next    = mzs_reg;

        // Stage C: elevation product, column offset
        ic_next  = inner_reg * cos_phi_reg;
        zs2_next = zs_reg;
        ex_next  = px_reg - range_min_reg;

        // Stage D: row offset
        dz       = ic_reg - zs2_reg;
        py       = dz[51:14];
        ey_next  = py - range_min_reg;
        ex2_next = ex_reg;

        // Stage E: magnitude times scale, split into partial products
        exw       = ex2_reg;
        magx      = exw[38] ? 39'(-exw) : 39'(exw);
        magy      = ey_reg[38] ? 39'(-ey_reg) : 39'(ey_reg);
        xlo_next  = 64'(magx[31:0]) * 64'(x_scale_reg);
        xhi_next  = 39'(magx[38:32]) * 39'(x_scale_reg);
        ylo_next  = 64'(magy[31:0]) * 64'(y_scale_reg);
        yhi_next  = 39'(magy[38:32]) * 39'(y_scale_reg);
        negx_next = exw[38];
        negy_next = ey_reg[38];

        // Stage F: combine partial products
        qx_next    = 40'(xhi_reg) + 40'(xlo_reg[63:32]);
        qy_next    = 40'(yhi_reg) + 40'(ylo_reg[63:32]);
        fy_next    = |ylo_reg[31:0];
        negx2_next = negx_reg;
        negy2_next = negy_reg;

        // Stage G: truncate toward zero, range check, store address
        bx_w  = negx2_reg ? 40'd0 : qx_reg;
        bx_ok = (!negx2_reg || (qx_reg == 40'd0)) && (bx_w < across);
        if (negy2_reg)
        begin
            by_ok = (qy_reg == 40'd0);
            by_w  = BMAX;
        end
        else if (!fy_reg)
        begin
            by_ok = (qy_reg <= BMAX);
            by_w  = BMAX - qy_reg;
        end
        else if (qy_reg < BMAX)
        begin
            by_ok = 1'b1;
            by_w  = BMAX - qy_reg - 40'd1;
        end
        else
        begin
            by_ok = (qy_reg == BMAX);
            by_w  = 40'd0;
        end
        bin_ok_next   = bx_ok && by_ok;
        bin_addr_next = ADDR_W'(32'(bx_w[BX_W-1:0]) * 32'(BINS_DOWN) + 32'(by_w[BY_W-1:0]));

        // Cell bins: bit k of the code is row bin k[1:0], column bin k[2]
        cell_bx   = 32'(col_reg) * 32'(BINS_PER_COL) + 32'(k_reg[2]);
        cell_by   = 32'(row_reg) * 32'(BINS_PER_ROW) + 32'(k_reg[1:0]);
        cell_addr = ADDR_W'(cell_bx * 32'(BINS_DOWN) + cell_by);

        clr_last     = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_we)
        begin
            clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;
        end

        ram_we    = cmd.clr_we || cmd.bin_we;
        ram_waddr = cmd.clr_we ? clr_cnt_reg : bin_addr_reg;
        ram_wdata = cmd.clr_we ? 16'd0
                  : ((ram_rdata == 16'hFFFF) ? ram_rdata : ram_rdata + 16'd1);
        ram_raddr = cmd.rd_issue ? cell_addr : bin_addr_reg;

        k_next = cmd.cap ? 3'd0 : (cmd.rd_issue ? k_reg + 3'd1 : k_reg);

        total_next = total_reg;
        code_next  = code_reg;
        if (cmd.cap)
        begin
            total_next = 19'd0;
            code_next  = 8'd0;
        end
        else if (acc_v_reg)
        begin
            total_next = total_reg + 19'(ram_rdata);
            if (ram_rdata != 16'd0) code_next[acc_k_reg] = 1'b1;
        end

        result_next = '0;
        case (req_reg)
            REQ_PLOT: result_next.in_range = bin_ok_reg;
            REQ_READ:
            begin
                result_next.cell_code   = code_reg;
                result_next.cell_total  = total_reg;
                result_next.color_class = (code_reg == 8'hFF) ? color_of(total_reg)
                                                              : COLOR_NONE;
            end
            default: result_next = '0;
        endcase
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            x_reg       <= item.coord_x;
            y_reg       <= item.coord_y;
            z_reg       <= item.coord_z;
            req_reg     <= item.req_type;
            col_reg     <= item.cell_col;
            row_reg     <= item.cell_row;
            cell_ok_reg <= cell_ok_next;
        end
        mxc_reg      <= mxc_next;
        mys_reg      <= mys_next;
        mxs_reg      <= mxs_next;
        myc_reg      <= myc_next;
        mzs_reg      <= mzs_next;
        px_reg       <= px_next;
        inner_reg    <= inner_next;
        zs_reg       <= zs_next;
        ic_reg       <= ic_next;
        zs2_reg      <= zs2_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ex2_reg      <= ex2_next;
        xlo_reg      <= xlo_next;
        xhi_reg      <= xhi_next;
        ylo_reg      <= ylo_next;
        yhi_reg      <= yhi_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        fy_reg       <= fy_next;
        negx2_reg    <= negx2_next;
        negy2_reg    <= negy2_next;
        bin_ok_reg   <= bin_ok_next;
        bin_addr_reg <= bin_addr_next;
        acc_k_reg    <= k_reg;
        total_reg    <= total_next;
        code_reg     <= code_next;
        if (cmd.fin)
        begin
            result_reg <= result_next;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            k_reg       <= 3'd0;
            acc_v_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            k_reg       <= k_next;
            acc_v_reg   <= cmd.rd_issue;
            done_reg    <= cmd.fin;
        end
    end

    rpdr_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.bin_ok   = bin_ok_reg;
    assign status.cell_ok  = cell_ok_reg;
    assign status.clr_last = clr_last;
    assign status.k_last   = (k_reg == 3'd7);
    assign result          = result_reg;
    assign done            = done_reg;

endmodule

### rtl/rotated_point_density_rasterizer_unit.sv
// Sequence: a plot runs the seven-stage projection pipeline, then the bin read and,
// if in range, the bin write; an in-grid cell read walks the eight bins of its cell;
// a read outside the grid and request code 3 go straight to the result; a clear
// sweeps the store. Throughput: one request at a time; the next transfer is taken at
// the edge ending the done cycle. Reset: clearing pass over all MAX_COLS*GRID_ROWS*8
// store entries (32768 default), busy high.
// ============================================================================
// rotated_point_density_rasterizer_unit
// Projects 3D points through a two-angle rotation into a grid of saturating
// bin counters and answers braille cell reads.
// ============================================================================
module rotated_point_density_rasterizer_unit #(
    parameter int MAX_COLS  = 128,
    parameter int GRID_ROWS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // Request side: a transfer happens when start is high and busy is low
    input  logic              start,
    output logic              busy,
    input  rpdr_pkg::item_t   item,
    // Result side: one-cycle strobe, always taken
    output logic              done,
    output rpdr_pkg::result_t result,
    // Register writes: the user must write only while idle; the block does not enforce it
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [31:0]       cfg_data
);
    import rpdr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: owns the request flow and the store sweep
    rpdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (item.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Datapath: config, projection pipeline, bin store, result register
    rpdr_datapath #(
        .MAX_COLS  (MAX_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .status   (status),
        .result   (result),
        .done     (done)
    );

endmodule
